[rtl/hbt_pkg.sv]
// Package for the handle bitmap table: item types, codes and helpers.
`timescale 1ns / 1ps

package hbt_pkg;

    localparam int BITS_PER_WORD   = 63;
    localparam int ID_SPAN         = 1024;
    localparam int TABLE_WORDS_DEF = 16;
    localparam int SLOT_WIDTH      = 64;

    localparam logic [1:0] OP_OPEN  = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_GET   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  handle;
        logic [47:0] object_addr;
        logic [15:0] rights;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  handle_out;
        logic [47:0] addr_out;
        logic [15:0] rights_out;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic find_word;
        logic find_bit;
        logic commit;
        logic split;
        logic respond;
    } hbt_cmd_t;

    // handle / 63 for handles below 1024: reciprocal 1041 / 2^16
    function automatic logic [4:0] div63(input logic [9:0] h);
        logic [20:0] prod;
        prod = 21'(h) * 21'd1041;
        return prod[20:16];
    endfunction

    // bits of word w that map to handle IDs 1 .. lim-1
    function automatic logic [62:0] avail_mask(input int w, input int lim);
        logic [62:0] m;
        int id;
        m = '0;
        for (int b = 0; b < BITS_PER_WORD; b++) begin
            id = w * BITS_PER_WORD + b;
            m[b] = (id >= 1) && (id < lim);
        end
        return m;
    endfunction

endpackage

[rtl/handle_bitmap_table_core.sv]
// Top level of the handle bitmap table: controller plus datapath.
//
// Usage:
//   Issue an item by raising start with the request struct (op, handle,
//   object_addr, rights); it is taken at a clock edge where busy is low.
//   Open claims the lowest free handle ID (word-major, lowest clear bit;
//   ID 0 is never given out), close releases an open ID, get reads back
//   the stored address and rights.
//   The result struct appears for exactly one cycle with done high; the
//   receiver has no way to stall it, so it must take it in that cycle.
// Sequence:
//   Open: after acceptance the controller finds the first word with a
//   free ID, then the lowest clear bit in it, then writes the bitmap and
//   slot RAM. Close/get: a split state, then a response state that uses
//   the slot RAM registered read. A new item can be accepted in the cycle
//   done is high, not before, since busy stays high until then.
// Reset:
//   rst_n clears the controller, the result strobe and the open bitmap.
//   Slot RAM needs no clearing pass: a slot is only read while its open
//   bit is set, and every open writes its slot first.
`timescale 1ns / 1ps

module handle_bitmap_table_core #(
    parameter int TABLE_WORDS = hbt_pkg::TABLE_WORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  hbt_pkg::request_t request,
    output logic              busy,
    output logic              done,
    output hbt_pkg::result_t  result
);
    import hbt_pkg::*;

    hbt_cmd_t cmd;

    hbt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (request.op),
        .busy  (busy),
        .cmd   (cmd)
    );

    hbt_datapath #(
        .TABLE_WORDS (TABLE_WORDS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // a result only shows once the controller is back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an accepted item always makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but controller stayed idle");

    // results never come back to back
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back result strobes");

    // handle_out is only nonzero on a successful open
    a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.handle_out != 10'd0)) |-> (result.status == ST_OK))
        else $error("handle returned with failing status");

endmodule

[rtl/hbt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hbt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1008
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/hbt_ctrl.sv]
// Controller state machine for the handle bitmap table.
`timescale 1ns / 1ps

module hbt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       op,
    output logic             busy,
    output hbt_pkg::hbt_cmd_t cmd
);
    import hbt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_FIND_WORD = 6'b000010,
        S_FIND_BIT  = 6'b000100,
        S_COMMIT    = 6'b001000,
        S_SPLIT     = 6'b010000,
        S_RESP      = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (op == OP_OPEN) ? S_FIND_WORD : S_SPLIT;
                end
            end
            S_FIND_WORD:
            begin
                cmd.find_word = 1'b1;
                state_next    = S_FIND_BIT;
            end
            S_FIND_BIT:
            begin
                cmd.find_bit = 1'b1;
                state_next   = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            S_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                cmd.respond = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[rtl/hbt_datapath.sv]
// Datapath: open bitmap, free search, handle split, slot RAM and result register.
`timescale 1ns / 1ps

module hbt_datapath #(
    parameter int TABLE_WORDS = hbt_pkg::TABLE_WORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hbt_pkg::hbt_cmd_t cmd,
    input  hbt_pkg::request_t request,
    output logic              done,
    output hbt_pkg::result_t  result
);
    import hbt_pkg::*;

    localparam int SLOTS = TABLE_WORDS * BITS_PER_WORD;
    localparam int LIM   = (SLOTS < ID_SPAN) ? SLOTS : ID_SPAN;
    localparam int NW    = (LIM + BITS_PER_WORD - 1) / BITS_PER_WORD;
    localparam int WW    = (NW > 1) ? $clog2(NW) : 1;
    localparam int AW    = $clog2(LIM);

    logic [62:0] avail [NW];
    logic [62:0] map_reg [NW];

    request_t    req_reg;
    logic [WW-1:0] word_reg;
    logic        any_free_reg;
    logic [5:0]  bit_reg;
    logic [9:0]  id_reg;
    logic [WW-1:0] w_reg;
    logic [5:0]  b_reg;
    logic        range_ok_reg;
    result_t     result_reg;
    logic        done_reg;

    for (genvar g = 0; g < NW; g++)
    begin : g_avail
        assign avail[g] = avail_mask(g, LIM);
    end

    // first word that still has a reachable free ID
    logic [NW-1:0] word_free;
    logic [WW-1:0] word_first;
    logic          any_free;

    always_comb
    begin
        word_first = '0;
        any_free   = 1'b0;
        for (int w = 0; w < NW; w++)
        begin
            word_free[w] = |(~map_reg[w] & avail[w]);
        end
        for (int w = NW - 1; w >= 0; w--)
        begin
            if (word_free[w])
            begin
                word_first = WW'(w);
                any_free   = 1'b1;
            end
        end
    end

    // lowest free bit of the chosen word
    logic [62:0] free_bits;
    logic [5:0]  bit_first;
    logic [9:0]  id_calc;

    always_comb
    begin
        free_bits = ~map_reg[word_reg] & avail[word_reg];
        bit_first = '0;
        for (int b = BITS_PER_WORD - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                bit_first = 6'(b);
            end
        end
        id_calc = ({5'(word_reg), 6'b0} - 11'(word_reg)) + 11'(bit_first) > 11'd0
                  ? 10'(({5'(word_reg), 6'b0} - 11'(word_reg)) + 11'(bit_first))
                  : 10'd0;
    end

    // handle -> word, bit
    logic [4:0]  h_word;
    logic [5:0]  h_bit;
    logic        range_ok;
    logic [10:0] h_word_x63;

    always_comb
    begin
        h_word     = div63(req_reg.handle);
        h_word_x63 = {h_word, 6'b0} - 11'(h_word);
        h_bit      = 6'(11'(req_reg.handle) - h_word_x63);
        range_ok   = (req_reg.handle != 10'd0) && ({1'b0, req_reg.handle} < 11'(LIM));
    end

    // slot RAM
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    logic [SLOT_WIDTH-1:0] ram_rdata;

    assign ram_we    = cmd.commit && any_free_reg;
    assign ram_waddr = id_reg[AW-1:0];
    assign ram_raddr = range_ok ? req_reg.handle[AW-1:0] : '0;

    hbt_ram #(
        .WIDTH (SLOT_WIDTH),
        .DEPTH (LIM)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({req_reg.rights, req_reg.object_addr}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // response for open
    result_t open_res;

    always_comb
    begin
        open_res            = '0;
        open_res.status     = any_free_reg ? ST_OK : ST_FULL;
        open_res.handle_out = any_free_reg ? id_reg : 10'd0;
    end

    // response for close / get
    logic    hit;
    result_t lookup_res;
    logic    clear_bit;

    always_comb
    begin
        hit        = range_ok_reg && map_reg[w_reg][b_reg];
        lookup_res = '0;
        lookup_res.status = ST_INVALID;
        clear_bit  = 1'b0;
        case (req_reg.op)
            OP_CLOSE:
            begin
                if (hit)
                begin
                    clear_bit         = 1'b1;
                    lookup_res.status = (ram_rdata == '0) ? ST_EMPTY : ST_OK;
                end
            end
            OP_GET:
            begin
                if (hit)
                begin
                    lookup_res.status     = ST_OK;
                    lookup_res.addr_out   = ram_rdata[47:0];
                    lookup_res.rights_out = ram_rdata[63:48];
                end
            end
            default:
            begin
                lookup_res.status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        if (cmd.find_word)
        begin
            word_reg     <= word_first;
            any_free_reg <= any_free;
        end
        if (cmd.find_bit)
        begin
            bit_reg <= bit_first;
            id_reg  <= id_calc;
        end
        if (cmd.split)
        begin
            w_reg        <= range_ok ? h_word[WW-1:0] : '0;
            b_reg        <= h_bit;
            range_ok_reg <= range_ok;
        end
        if (cmd.commit)
        begin
            result_reg <= open_res;
        end
        else if (cmd.respond)
        begin
            result_reg <= lookup_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NW; w++)
            begin
                map_reg[w] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.commit || cmd.respond;
            if (cmd.commit && any_free_reg)
            begin
                map_reg[word_reg][bit_reg] <= 1'b1;
            end
            else if (cmd.respond && clear_bit)
            begin
                map_reg[w_reg][b_reg] <= 1'b0;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
